// File: hw/rtl/mtt_pkg.sv
// mtt_pkg: shared types and codes for the multi-timer table.
// Holds command, result kind, status and write-mode codes plus the
// controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package mtt_pkg;

    localparam int TIME_W   = 32;
    localparam int OUT_ID_W = 16;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] KIND_ADD       = 2'd0;
    localparam logic [1:0] KIND_REMOVE    = 2'd1;
    localparam logic [1:0] KIND_FIRED     = 2'd2;
    localparam logic [1:0] KIND_TICK_DONE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    typedef logic [1:0] wr_mode_t;
    localparam wr_mode_t WR_NEW  = 2'd0;
    localparam wr_mode_t WR_FIRE = 2'd1;
    localparam wr_mode_t WR_COPY = 2'd2;

    typedef logic [1:0] id_sel_t;
    localparam id_sel_t ID_SEL_NONE = 2'd0;
    localparam id_sel_t ID_SEL_NEW  = 2'd1;
    localparam id_sel_t ID_SEL_REQ  = 2'd2;
    localparam id_sel_t ID_SEL_SLOT = 2'd3;

    typedef struct packed {
        logic       load;
        logic       wr_en;
        wr_mode_t   wr_mode;
        logic       acc_clear;
        logic       acc_upd;
        logic       emit;
        logic [1:0] emit_kind;
        logic [1:0] emit_status;
        id_sel_t    emit_id;
        logic       emit_last;
        logic       empty;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic rid_zero;
        logic match;
        logic due;
        logic done;
        logic id_max;
    } dp_sts_t;

endpackage

// File: hw/rtl/multi_timer_table.sv
// multi_timer_table: top level of the software-style timer table.
// Instantiates mtt_ctrl and mtt_datapath; depends on mtt_pkg.
//
// Usage: commands enter on the s_ stream (s_tuser selects tick, add or
// remove), results leave on the m_ stream (m_tuser gives the result kind,
// m_tlast marks the final result of a command). Live timers are kept
// packed in ascending id order, so a tick is one pass over the live entries.
// Command steps, with n live timers:
//   add     - a single result follows the transaction.
//   remove  - scan for the id, then shift the entries above it down one
//             per cycle.
//   tick    - one pass over the n live entries, then the tick-finished result;
//             the fired results, one per due timer, leave during the scan.
// The block takes one command at a time; s_tready is high only while no
// command is in progress.
// A stalled receiver holds the output register and pauses the scan.
// Reset empties the table and drops any pending result; no clearing pass.
`timescale 1ns / 1ps

module multi_timer_table import mtt_pkg::*; #(
    parameter int NUM_TIMERS = 16,
    parameter int ID_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // now_ms, period_ms, repeating, remove_id
    input  logic [1:0]  s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // status, result_id, next_wait_ms
    output logic [1:0]  m_tuser,  // kind
    output logic        m_tlast
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;

    mtt_ctrl #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .rd_idx   (rd_idx),
        .wr_idx   (wr_idx)
    );

    mtt_datapath #(
        .NUM_TIMERS(NUM_TIMERS),
        .ID_BITS   (ID_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .wr_idx   (wr_idx),
        .sts      (sts)
    );

    a_fired_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_FIRED |-> !m_tlast)
        else $error("fired result marked last");

    a_reply_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ADD || m_tuser == KIND_REMOVE) |-> m_tlast)
        else $error("add or remove reply not marked last");

    a_wait_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_TICK_DONE |-> m_tdata[49:18] == 32'd0)
        else $error("nonzero wait outside tick-finished result");

endmodule

// File: hw/rtl/mtt_datapath.sv
// mtt_datapath: timer slot storage, item registers, deadline arithmetic,
// next-wait accumulator and the result output register.
// Depends on mtt_pkg; driven by mtt_ctrl.
`timescale 1ns / 1ps

module mtt_datapath import mtt_pkg::*; #(
    parameter int  NUM_TIMERS = 16,
    parameter int  ID_BITS    = 16,
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [87:0]      s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    input  dp_cmd_t          cmd,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic [IDX_W-1:0] wr_idx,
    output dp_sts_t          sts
);

    localparam int CMPW = (ID_BITS > OUT_ID_W) ? ID_BITS : OUT_ID_W;

    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   period_reg;
    logic                rep_reg;
    logic [OUT_ID_W-1:0] rid_reg;

    logic [ID_BITS-1:0] ident_mem    [NUM_TIMERS];
    logic [TIME_W-1:0]  period_mem   [NUM_TIMERS];
    logic               periodic_mem [NUM_TIMERS];
    logic               done_mem     [NUM_TIMERS];
    logic [TIME_W-1:0]  deadline_mem [NUM_TIMERS];

    logic [ID_BITS-1:0] rd_ident;
    logic [TIME_W-1:0]  rd_period;
    logic               rd_periodic;
    logic               rd_done;
    logic [TIME_W-1:0]  rd_deadline;

    logic [TIME_W-1:0]  diff;
    logic               due;
    logic [TIME_W-1:0]  sum;
    logic [ID_BITS-1:0] new_id;
    logic [CMPW-1:0]    new_ext;
    logic [CMPW-1:0]    rd_ext;
    logic [CMPW-1:0]    rid_ext;

    logic              acc_valid_reg, acc_valid_next;
    logic [TIME_W-1:0] acc_reg, acc_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg;
    logic [1:0]          out_status_reg;
    logic [OUT_ID_W-1:0] out_id_reg, out_id_next;
    logic [TIME_W-1:0]   out_wait_reg, out_wait_next;
    logic                out_last_reg;
    logic                out_free;

    assign rd_ident    = ident_mem[rd_idx];
    assign rd_period   = period_mem[rd_idx];
    assign rd_periodic = periodic_mem[rd_idx];
    assign rd_done     = done_mem[rd_idx];
    assign rd_deadline = deadline_mem[rd_idx];

    assign diff   = rd_deadline - now_reg;
    assign due    = (diff == '0) || diff[TIME_W-1];
    assign sum    = now_reg + ((cmd.wr_mode == WR_FIRE) ? rd_period : period_reg);
    assign new_id = cmd.empty ? ID_BITS'(1) : rd_ident + ID_BITS'(1);

    assign new_ext = CMPW'(new_id);
    assign rd_ext  = CMPW'(rd_ident);
    assign rid_ext = CMPW'(rid_reg);

    assign out_free = !out_valid_reg || m_tready;

    assign sts.out_free = out_free;
    assign sts.rid_zero = (rid_reg == '0);
    assign sts.match    = (rd_ext == rid_ext);
    assign sts.due      = due;
    assign sts.done     = rd_done;
    assign sts.id_max   = &rd_ident;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg    <= s_tdata[31:0];
            period_reg <= s_tdata[63:32];
            rep_reg    <= s_tdata[64];
            rid_reg    <= s_tdata[80:65];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            unique case (cmd.wr_mode)
                WR_NEW: begin
                    ident_mem[wr_idx]    <= new_id;
                    period_mem[wr_idx]   <= period_reg;
                    periodic_mem[wr_idx] <= rep_reg;
                    done_mem[wr_idx]     <= 1'b0;
                    deadline_mem[wr_idx] <= sum;
                end
                WR_FIRE: begin
                    deadline_mem[wr_idx] <= sum;
                    done_mem[wr_idx]     <= !rd_periodic;
                end
                WR_COPY: begin
                    ident_mem[wr_idx]    <= rd_ident;
                    period_mem[wr_idx]   <= rd_period;
                    periodic_mem[wr_idx] <= rd_periodic;
                    done_mem[wr_idx]     <= rd_done;
                    deadline_mem[wr_idx] <= rd_deadline;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        acc_valid_next = acc_valid_reg;
        acc_next       = acc_reg;
        if (cmd.acc_clear) begin
            acc_valid_next = 1'b0;
        end else if (cmd.acc_upd) begin
            if (due) begin
                acc_valid_next = 1'b1;
                acc_next       = '0;
            end else if (!acc_valid_reg || diff < acc_reg) begin
                acc_valid_next = 1'b1;
                acc_next       = diff;
            end
        end
    end

    always_comb begin
        unique case (cmd.emit_id)
            ID_SEL_NONE: out_id_next = '0;
            ID_SEL_NEW:  out_id_next = new_ext[OUT_ID_W-1:0];
            ID_SEL_REQ:  out_id_next = rid_reg;
            ID_SEL_SLOT: out_id_next = rd_ext[OUT_ID_W-1:0];
            default:     out_id_next = '0;
        endcase
        if (cmd.emit_kind == KIND_TICK_DONE) begin
            out_wait_next = acc_valid_reg ? acc_reg : '1;
        end else begin
            out_wait_next = '0;
        end
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            acc_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            acc_valid_reg <= acc_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.emit) begin
            out_kind_reg   <= cmd.emit_kind;
            out_status_reg <= cmd.emit_status;
            out_id_reg     <= out_id_next;
            out_wait_reg   <= out_wait_next;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_wait_reg, out_id_reg, out_status_reg};

endmodule

// File: hw/rtl/mtt_ctrl.sv
// mtt_ctrl: command sequencer for the multi-timer table. Tracks the live
// entry count and the scan position, and drives mtt_datapath.
// Depends on mtt_pkg.
`timescale 1ns / 1ps

module mtt_ctrl import mtt_pkg::*; #(
    parameter int  NUM_TIMERS = 16,
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       s_cmd,
    output dp_cmd_t          cmd,
    input  dp_sts_t          sts,
    output logic [IDX_W-1:0] rd_idx,
    output logic [IDX_W-1:0] wr_idx
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD      = 3'd1;
    localparam logic [2:0] S_RM_SCAN  = 3'd2;
    localparam logic [2:0] S_RM_SHIFT = 3'd3;
    localparam logic [2:0] S_TICK     = 3'd4;
    localparam logic [2:0] S_TICK_END = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] pos_prev;
    logic             at_end;

    assign s_tready = (state_reg == S_IDLE);
    assign rd_idx   = pos_reg[IDX_W-1:0];
    assign pos_prev = pos_reg - CNT_W'(1);
    assign at_end   = (pos_reg == count_reg);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        cmd        = '0;
        wr_idx     = pos_reg[IDX_W-1:0];
        cmd.empty  = (count_reg == '0);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    pos_next = '0;
                    unique case (s_cmd)
                        CMD_ADD: begin
                            if (count_reg != '0) begin
                                pos_next = count_reg - CNT_W'(1);
                            end
                            state_next = S_ADD;
                        end
                        CMD_REMOVE: state_next = S_RM_SCAN;
                        CMD_TICK: begin
                            cmd.acc_clear = 1'b1;
                            state_next    = S_TICK;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                wr_idx = count_reg[IDX_W-1:0];
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ADD;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                    if (count_reg == CNT_W'(NUM_TIMERS)) begin
                        cmd.emit_status = ST_FULL;
                    end else if (count_reg != '0 && sts.id_max) begin
                        cmd.emit_status = ST_OVERFLOW;
                    end else begin
                        cmd.emit_status = ST_OK;
                        cmd.emit_id     = ID_SEL_NEW;
                        cmd.wr_en       = 1'b1;
                        cmd.wr_mode     = WR_NEW;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
            end
            S_RM_SCAN: begin
                if (sts.rid_zero || at_end) begin
                    if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = KIND_REMOVE;
                        cmd.emit_last   = 1'b1;
                        cmd.emit_status = sts.rid_zero ? ST_OK : ST_NOT_FOUND;
                        cmd.emit_id     = sts.rid_zero ? ID_SEL_NONE : ID_SEL_REQ;
                        state_next      = S_IDLE;
                    end
                end else begin
                    pos_next = pos_reg + CNT_W'(1);
                    if (sts.match) begin
                        state_next = S_RM_SHIFT;
                    end
                end
            end
            S_RM_SHIFT: begin
                wr_idx = pos_prev[IDX_W-1:0];
                if (at_end) begin
                    if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = KIND_REMOVE;
                        cmd.emit_last   = 1'b1;
                        cmd.emit_status = ST_OK;
                        cmd.emit_id     = ID_SEL_REQ;
                        count_next      = count_reg - CNT_W'(1);
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_mode = WR_COPY;
                    pos_next    = pos_reg + CNT_W'(1);
                end
            end
            S_TICK: begin
                if (at_end) begin
                    state_next = S_TICK_END;
                end else if (sts.done) begin
                    pos_next = pos_reg + CNT_W'(1);
                end else if (sts.due) begin
                    if (sts.out_free) begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_mode     = WR_FIRE;
                        cmd.acc_upd     = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = KIND_FIRED;
                        cmd.emit_status = ST_OK;
                        cmd.emit_id     = ID_SEL_SLOT;
                        pos_next        = pos_reg + CNT_W'(1);
                    end
                end else begin
                    cmd.acc_upd = 1'b1;
                    pos_next    = pos_reg + CNT_W'(1);
                end
            end
            S_TICK_END: begin
                if (sts.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = KIND_TICK_DONE;
                    cmd.emit_status = ST_OK;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

endmodule
